// File: hw/rtl/uihp_pkg.sv
// ----------------------------------------------------------------------------
// Upgrade image header parser package
// Types and constants shared by the parser modules: channel payloads, the
// parse phase, event kinds and status codes, header offsets.
// ----------------------------------------------------------------------------
package uihp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [7:0]  action_code;
      logic [7:0]  action_components;
      logic [31:0] payload_length;
      logic [31:0] payload_offset;
      logic [7:0]  device_number;
      logic [23:0] vendor_number;
      logic [15:0] product_number;
      logic [7:0]  capability_flags;
      logic [7:0]  component_mask;
      logic [15:0] earliest_version;
   } rsp_type;

   // settings handed from the register block to the parser
   typedef struct packed {
      logic        check_one_component;
      logic [31:0] record_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_OEM,
      PH_BOUNDARY,
      PH_COMP,
      PH_SUM,
      PH_UPFIXED,
      PH_UPLEN,
      PH_PAYLOAD,
      PH_DONE,
      PH_ERROR
   } phase_type;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_ACTION = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SIGNATURE  = 3'd1;
   localparam logic [2:0] ST_VERSION    = 3'd2;
   localparam logic [2:0] ST_HDR_SUM    = 3'd3;
   localparam logic [2:0] ST_ACTION_SUM = 3'd4;
   localparam logic [2:0] ST_COMPONENT  = 3'd5;
   localparam logic [2:0] ST_TRUNCATED  = 3'd6;

   // register index decode (paddr[2])
   localparam logic REG_CHECK_ONE    = 1'b0;
   localparam logic REG_IMAGE_LENGTH = 1'b1;
   localparam int   PADDR_WIDTH      = 3;

   localparam logic [7:0] ACTION_UPLOAD = 8'h02;

   localparam logic [7:0] SIGNATURE [8] = '{8'h50, 8'h49, 8'h43, 8'h4D,
                                            8'h47, 8'h46, 8'h57, 8'h55};

   // header byte offsets
   localparam logic [5:0] POS_SIG_END    = 6'd8;
   localparam logic [5:0] POS_VERSION    = 6'd8;
   localparam logic [5:0] POS_DEVICE     = 6'd9;
   localparam logic [5:0] POS_MANUF_0    = 6'd10;
   localparam logic [5:0] POS_MANUF_1    = 6'd11;
   localparam logic [5:0] POS_MANUF_2    = 6'd12;
   localparam logic [5:0] POS_PRODUCT_0  = 6'd13;
   localparam logic [5:0] POS_PRODUCT_1  = 6'd14;
   localparam logic [5:0] POS_CAPS       = 6'd19;
   localparam logic [5:0] POS_COMPONENTS = 6'd20;
   localparam logic [5:0] POS_EARLY_MAJ  = 6'd24;
   localparam logic [5:0] POS_EARLY_MIN  = 6'd25;
   localparam logic [5:0] POS_OEM_LEN_0  = 6'd32;
   localparam logic [5:0] POS_OEM_LEN_1  = 6'd33;
   localparam logic [5:0] POS_HDR_SUM    = 6'd34;

   localparam logic [4:0] UPLOAD_FIXED_BYTES = 5'd27;
   localparam logic [4:0] LENGTH_LAST_INDEX  = 5'd3;

endpackage

// File: hw/rtl/uihp_csr.sv
// ----------------------------------------------------------------------------
// Upgrade image header parser register block
// APB-style register file: component check enable and image length. The
// record start limit (image length minus trailer) is registered at write.
// ----------------------------------------------------------------------------
module uihp_csr #(
   parameter int TRAILER_BYTES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [uihp_pkg::PADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output uihp_pkg::cfg_type                 cfg
);

   localparam logic [31:0] TRAILER = 32'(TRAILER_BYTES);

   logic        check_one_ff, check_one_in;
   logic [31:0] image_length_ff, image_length_in;
   logic [31:0] limit_ff, limit_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      check_one_in    = check_one_ff;
      image_length_in = image_length_ff;
      limit_in        = limit_ff;
      if (wr_en) begin
         unique case (paddr[2])
            uihp_pkg::REG_CHECK_ONE: begin
               check_one_in = pwdata[0];
            end
            uihp_pkg::REG_IMAGE_LENGTH: begin
               image_length_in = pwdata;
               limit_in        = (pwdata >= TRAILER) ? pwdata - TRAILER : 32'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_one_ff    <= 1'b0;
         image_length_ff <= 32'd0;
         limit_ff        <= 32'd0;
      end else begin
         check_one_ff    <= check_one_in;
         image_length_ff <= image_length_in;
         limit_ff        <= limit_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         uihp_pkg::REG_CHECK_ONE:    prdata = {31'd0, check_one_ff};
         uihp_pkg::REG_IMAGE_LENGTH: prdata = image_length_ff;
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg.check_one_component = check_one_ff;
   assign cfg.record_limit        = limit_ff;

endmodule

// File: hw/rtl/uihp_parse_core.sv
// ----------------------------------------------------------------------------
// Upgrade image header parser core
// Per-byte parse state machine: header checks and capture, OEM skip, action
// record parsing, payload skip, end-of-image handling.
// ----------------------------------------------------------------------------
module uihp_parse_core #(
   parameter int MAX_ACTIONS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  uihp_pkg::req_type item,
   input  uihp_pkg::cfg_type cfg,
   output logic              res_valid,
   output uihp_pkg::rsp_type res
);

   localparam int          CW      = $clog2(MAX_ACTIONS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ACTIONS);

   uihp_pkg::phase_type phase_ff, phase_in;
   logic [31:0]   pos_ff, pos_in;
   logic [7:0]    sum_ff, sum_in;
   logic [4:0]    fidx_ff, fidx_in;
   logic [15:0]   oem_ff, oem_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   len_ff, len_in;
   logic [31:0]   skip_ff, skip_in;
   logic [7:0]    code_ff, code_in;
   logic [7:0]    comp_ff, comp_in;
   logic [7:0]    dev_ff, dev_in;
   logic [23:0]   manuf_ff, manuf_in;
   logic [15:0]   prod_ff, prod_in;
   logic [7:0]    caps_ff, caps_in;
   logic [7:0]    mask_ff, mask_in;
   logic [15:0]   early_ff, early_in;

   always_comb begin
      logic [7:0]  b;
      logic [5:0]  p6;
      logic [31:0] pos_inc;
      logic [31:0] skip_dec;
      logic [31:0] len_full;
      logic [7:0]  csum;
      logic        finished;
      logic        one_hot;

      b        = item.data_byte;
      p6       = pos_ff[5:0];
      pos_inc  = pos_ff + 32'd1;
      skip_dec = skip_ff - {31'd0, (skip_ff != 32'd0)};
      len_full = {b, len_ff[23:0]};
      csum     = 8'd0 - code_ff - comp_ff;
      finished = (phase_ff == uihp_pkg::PH_DONE) || (phase_ff == uihp_pkg::PH_ERROR);
      one_hot  = (comp_ff != 8'd0) && ((comp_ff & (comp_ff - 8'd1)) == 8'd0);

      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      fidx_in  = fidx_ff;
      oem_in   = oem_ff;
      count_in = count_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      code_in  = code_ff;
      comp_in  = comp_ff;
      dev_in   = dev_ff;
      manuf_in = manuf_ff;
      prod_in  = prod_ff;
      caps_in  = caps_ff;
      mask_in  = mask_ff;
      early_in = early_ff;
      res_valid = 1'b0;
      res       = '0;

      if (!finished) begin
         pos_in = pos_inc;
         unique case (phase_ff)
            uihp_pkg::PH_HEADER: begin
               if (p6 < uihp_pkg::POS_SIG_END && b != uihp_pkg::SIGNATURE[p6[2:0]]) begin
                  phase_in   = uihp_pkg::PH_ERROR;
                  res_valid  = 1'b1;
                  res.kind   = uihp_pkg::KIND_ERROR;
                  res.status = uihp_pkg::ST_SIGNATURE;
               end else if (p6 == uihp_pkg::POS_VERSION && b != 8'd0) begin
                  phase_in   = uihp_pkg::PH_ERROR;
                  res_valid  = 1'b1;
                  res.kind   = uihp_pkg::KIND_ERROR;
                  res.status = uihp_pkg::ST_VERSION;
               end else begin
                  if (p6 < uihp_pkg::POS_HDR_SUM) sum_in = sum_ff - b;
                  case (p6)
                     uihp_pkg::POS_DEVICE:     dev_in          = b;
                     uihp_pkg::POS_MANUF_0:    manuf_in[7:0]   = b;
                     uihp_pkg::POS_MANUF_1:    manuf_in[15:8]  = b;
                     uihp_pkg::POS_MANUF_2:    manuf_in[23:16] = b;
                     uihp_pkg::POS_PRODUCT_0:  prod_in[7:0]    = b;
                     uihp_pkg::POS_PRODUCT_1:  prod_in[15:8]   = b;
                     uihp_pkg::POS_CAPS:       caps_in         = b;
                     uihp_pkg::POS_COMPONENTS: mask_in         = b;
                     uihp_pkg::POS_EARLY_MAJ:  early_in[15:8]  = b;
                     uihp_pkg::POS_EARLY_MIN:  early_in[7:0]   = b;
                     uihp_pkg::POS_OEM_LEN_0:  oem_in[7:0]     = b;
                     uihp_pkg::POS_OEM_LEN_1:  oem_in[15:8]    = b;
                     uihp_pkg::POS_HDR_SUM: begin
                        res_valid = 1'b1;
                        if (b != sum_ff) begin
                           phase_in   = uihp_pkg::PH_ERROR;
                           res.kind   = uihp_pkg::KIND_ERROR;
                           res.status = uihp_pkg::ST_HDR_SUM;
                        end else begin
                           res.kind             = uihp_pkg::KIND_HEADER;
                           res.device_number    = dev_ff;
                           res.vendor_number    = manuf_ff;
                           res.product_number   = prod_ff;
                           res.capability_flags = caps_ff;
                           res.component_mask   = mask_ff;
                           res.earliest_version = early_ff;
                           skip_in  = {16'd0, oem_ff};
                           phase_in = (oem_ff != 16'd0) ? uihp_pkg::PH_OEM
                                                        : uihp_pkg::PH_BOUNDARY;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            uihp_pkg::PH_OEM, uihp_pkg::PH_PAYLOAD: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) phase_in = uihp_pkg::PH_BOUNDARY;
            end
            uihp_pkg::PH_BOUNDARY: begin
               if (count_ff == CNT_MAX || pos_ff >= cfg.record_limit) begin
                  phase_in  = uihp_pkg::PH_DONE;
                  res_valid = 1'b1;
                  res.kind  = uihp_pkg::KIND_DONE;
               end else begin
                  code_in  = b;
                  phase_in = uihp_pkg::PH_COMP;
               end
            end
            uihp_pkg::PH_COMP: begin
               comp_in  = b;
               phase_in = uihp_pkg::PH_SUM;
            end
            uihp_pkg::PH_SUM: begin
               if (b != csum) begin
                  phase_in   = uihp_pkg::PH_ERROR;
                  res_valid  = 1'b1;
                  res.kind   = uihp_pkg::KIND_ERROR;
                  res.status = uihp_pkg::ST_ACTION_SUM;
               end else if (code_ff == uihp_pkg::ACTION_UPLOAD &&
                            cfg.check_one_component && !one_hot) begin
                  phase_in   = uihp_pkg::PH_ERROR;
                  res_valid  = 1'b1;
                  res.kind   = uihp_pkg::KIND_ERROR;
                  res.status = uihp_pkg::ST_COMPONENT;
               end else begin
                  if (count_ff != CNT_MAX) count_in = count_ff + CW'(1);
                  if (code_ff == uihp_pkg::ACTION_UPLOAD) begin
                     fidx_in  = 5'd0;
                     phase_in = uihp_pkg::PH_UPFIXED;
                  end else begin
                     res_valid             = 1'b1;
                     res.kind              = uihp_pkg::KIND_ACTION;
                     res.action_code       = code_ff;
                     res.action_components = comp_ff;
                     phase_in              = uihp_pkg::PH_BOUNDARY;
                  end
               end
            end
            uihp_pkg::PH_UPFIXED: begin
               fidx_in = fidx_ff + 5'd1;
               if (fidx_ff + 5'd1 >= uihp_pkg::UPLOAD_FIXED_BYTES) begin
                  fidx_in  = 5'd0;
                  phase_in = uihp_pkg::PH_UPLEN;
               end
            end
            uihp_pkg::PH_UPLEN: begin
               // length arrives little-endian, one lane per byte
               len_in[fidx_ff[1:0]*8 +: 8] = b;
               fidx_in = fidx_ff + 5'd1;
               if (fidx_ff == uihp_pkg::LENGTH_LAST_INDEX) begin
                  res_valid             = 1'b1;
                  res.kind              = uihp_pkg::KIND_ACTION;
                  res.action_code       = code_ff;
                  res.action_components = comp_ff;
                  res.payload_length    = len_full;
                  res.payload_offset    = pos_inc;
                  skip_in  = len_full;
                  phase_in = (len_full != 32'd0) ? uihp_pkg::PH_PAYLOAD
                                                 : uihp_pkg::PH_BOUNDARY;
               end
            end
            default: ;
         endcase
      end

      if (item.last) begin
         // image end mid-parse: done at a boundary at cap or limit, else truncated
         if (!finished && phase_in != uihp_pkg::PH_DONE && phase_in != uihp_pkg::PH_ERROR) begin
            res_valid = 1'b1;
            res       = '0;
            if (phase_in == uihp_pkg::PH_BOUNDARY &&
                (count_in == CNT_MAX || pos_inc >= cfg.record_limit)) begin
               res.kind = uihp_pkg::KIND_DONE;
            end else begin
               res.kind   = uihp_pkg::KIND_ERROR;
               res.status = uihp_pkg::ST_TRUNCATED;
            end
         end
         phase_in = uihp_pkg::PH_HEADER;
         pos_in   = 32'd0;
         sum_in   = 8'd0;
         fidx_in  = 5'd0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uihp_pkg::PH_HEADER;
         pos_ff   <= 32'd0;
         sum_ff   <= 8'd0;
         fidx_ff  <= 5'd0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         fidx_ff  <= fidx_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         oem_ff   <= oem_in;
         len_ff   <= len_in;
         skip_ff  <= skip_in;
         code_ff  <= code_in;
         comp_ff  <= comp_in;
         dev_ff   <= dev_in;
         manuf_ff <= manuf_in;
         prod_ff  <= prod_in;
         caps_ff  <= caps_in;
         mask_ff  <= mask_in;
         early_ff <= early_in;
      end
   end

endmodule

// File: hw/rtl/upgrade_image_header_parser_unit.sv
// ----------------------------------------------------------------------------
// Upgrade image header parser unit
// Streams a firmware upgrade image one byte per transaction and reports
// header, action record, error and done events.
// ----------------------------------------------------------------------------
// One byte per clock unless rsp_ready stalls: each accepted byte is held in
// the input register, passes the single parse stage and lands in the result
// register, from which its event is presented. The only stall comes from
// rsp_ready: the parse stage advances whenever the result register is empty
// or is being drained. Bytes after an error or done event are absorbed with
// no result until the last-marked byte rearms the parser. The user must write
// registers only while no bytes are in flight; the block does not enforce it.
module upgrade_image_header_parser_unit #(
   parameter int MAX_ACTIONS   = 8,
   parameter int TRAILER_BYTES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  uihp_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output uihp_pkg::rsp_type                rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [uihp_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   uihp_pkg::cfg_type cfg;
   uihp_pkg::req_type in_item_ff;
   uihp_pkg::rsp_type out_item_ff;
   uihp_pkg::rsp_type res;
   logic              in_valid_ff;
   logic              out_valid_ff;
   logic              res_valid;
   logic              step;

   uihp_csr #(
      .TRAILER_BYTES (TRAILER_BYTES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   uihp_parse_core #(
      .MAX_ACTIONS (MAX_ACTIONS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign step      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // a new event is only loaded by a parse step
   a_event_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step))
      else $error("result appeared without a parse step");

   a_error_has_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == uihp_pkg::KIND_ERROR)
         |-> (rsp_payload.status != uihp_pkg::ST_OK))
      else $error("error event with ok status");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != uihp_pkg::KIND_ERROR)
         |-> (rsp_payload.status == uihp_pkg::ST_OK))
      else $error("non-error event with error status");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled while pipeline can advance");

endmodule
